// ===== hw/rtl/priority_event_queue_with_dependencies_assert.svh =====
// ----------------------------------------------------------------------------
// priority_event_queue_with_dependencies_assert
// Assertion macros used by the engine RTL file.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_EVENT_QUEUE_WITH_DEPENDENCIES_ASSERT_SVH
`define PRIORITY_EVENT_QUEUE_WITH_DEPENDENCIES_ASSERT_SVH

// Expression must hold at every clock edge outside reset.
`define PEQD_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PEQD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/peqd_pkg.sv =====
// ----------------------------------------------------------------------------
// peqd_pkg
// Types and constants of the priority event queue with dependencies.
// ----------------------------------------------------------------------------
package peqd_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int MAX_DEPENDS_DEF = 4;
   localparam int ID_W            = 63;
   localparam int DEP_SLOTS       = 4;

   localparam logic [ID_W-1:0] ID_MAX = {ID_W{1'b1}};

   localparam logic [2:0] ST_ADDED     = 3'd0;
   localparam logic [2:0] ST_TOO_MANY  = 3'd1;
   localparam logic [2:0] ST_POOL_FULL = 3'd2;
   localparam logic [2:0] ST_POPPED    = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   localparam logic ACT_ADD = 1'b0;
   localparam logic ACT_POP = 1'b1;

   typedef struct packed {
      logic            action;
      logic [7:0]      priority_req;
      logic [31:0]     handler;
      logic [31:0]     user_context;
      logic [2:0]      dep_count;
      logic [ID_W-1:0] dep_id_0;
      logic [ID_W-1:0] dep_id_1;
      logic [ID_W-1:0] dep_id_2;
      logic [ID_W-1:0] dep_id_3;
   } peqd_req_type;

   typedef struct packed {
      logic [2:0]      status;
      logic [ID_W-1:0] evt_id;
      logic [7:0]      out_priority;
      logic [31:0]     out_handler;
      logic [31:0]     out_context;
      logic [4:0]      queue_count;
   } peqd_rsp_type;

   // Classified request handed from front to engine.
   typedef struct packed {
      logic         bad_deps;
      peqd_req_type req;
   } peqd_cmd_type;

endpackage

// ===== hw/rtl/peqd_front.sv =====
// ----------------------------------------------------------------------------
// peqd_front
// Accepts requests, flags oversized dependency lists, two-entry queue.
// ----------------------------------------------------------------------------
module peqd_front import peqd_pkg::*; #(
   parameter int MAX_DEPENDS = MAX_DEPENDS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  peqd_req_type req_data,
   output logic         cmd_valid,
   output peqd_cmd_type cmd,
   input  logic         cmd_take
);

   peqd_cmd_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;
   peqd_cmd_type cls;

   always_comb begin
      cls.req      = req_data;
      cls.bad_deps = (32'(req_data.dep_count) > MAX_DEPENDS);
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_take;
   assign cmd       = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign count_in  = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

// ===== hw/rtl/peqd_engine.sv =====
// ----------------------------------------------------------------------------
// peqd_engine
// Slot store, priority list and dependency walk; registered response.
// ----------------------------------------------------------------------------
module peqd_engine import peqd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int MAX_DEPENDS = MAX_DEPENDS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         cmd_valid,
   input  peqd_cmd_type cmd,
   output logic         cmd_take,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output peqd_rsp_type rsp_data
);

`include "priority_event_queue_with_dependencies_assert.svh"

   localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int PW = $clog2(QUEUE_DEPTH + 1);
   localparam int DW = (MAX_DEPENDS > 1) ? $clog2(MAX_DEPENDS) : 1;
   localparam logic [PW-1:0] NONE  = PW'(QUEUE_DEPTH);
   localparam logic [PW-1:0] DEPTH = PW'(QUEUE_DEPTH);

   typedef enum logic [1:0] {S_IDLE, S_ADD_WALK, S_POP_SCAN, S_POP_FIN} state_type;

   // slot store; one packed dependency word per slot
   logic [QUEUE_DEPTH-1:0]             valid_ff;
   logic [7:0]                         prio_ff    [QUEUE_DEPTH];
   logic [ID_W-1:0]                    id_ff      [QUEUE_DEPTH];
   logic [31:0]                        hnd_ff     [QUEUE_DEPTH];
   logic [31:0]                        ctx_ff     [QUEUE_DEPTH];
   logic [MAX_DEPENDS-1:0][ID_W-1:0]   deps_ff    [QUEUE_DEPTH];
   logic [PW-1:0]                      link_ff    [QUEUE_DEPTH];
   logic [PW-1:0]                      head_ff;
   logic [ID_W-1:0]                    id_ctr_ff;
   logic [PW-1:0]                      used_ff;

   // sequencer
   state_type              state_ff;
   logic [IW-1:0]          new_slot_ff;
   logic [7:0]             add_prio_ff;
   logic [PW-1:0]          walk_ff;
   logic [PW-1:0]          prev_ff;
   logic [IW-1:0]          cur_ff;
   logic [PW-1:0]          n_ff;
   logic [DW-1:0]          dep_idx_ff;
   logic [IW-1:0]          last_slot_ff;
   logic [DW-1:0]          last_via_ff;
   logic                   rsp_valid_ff;
   peqd_rsp_type           rsp_ff;

   logic [IW-1:0]          free_slot;
   logic [IW-1:0]          match_slot;
   logic                   match_hit;
   logic [IW-1:0]          pred_slot;
   logic                   pred_hit;
   logic [ID_W-1:0]        dep_cur;
   logic [ID_W-1:0]        dep_in [DEP_SLOTS];
   logic [ID_W-1:0]        id_next;
   logic                   out_free;
   logic [IW-1:0]          walk_idx;

   // response carrying only a status and the queue count
   function automatic peqd_rsp_type status_rsp(input logic [2:0] st,
                                               input logic [PW-1:0] cnt);
      return {st, {(ID_W + 72){1'b0}}, 5'(cnt)};
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign cmd_take  = (state_ff == S_IDLE) && out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign id_next   = id_ctr_ff + ID_W'(1);
   assign dep_cur   = deps_ff[cur_ff][dep_idx_ff];
   assign walk_idx  = walk_ff[IW-1:0];

   always_comb begin
      dep_in[0] = cmd.req.dep_id_0;
      dep_in[1] = cmd.req.dep_id_1;
      dep_in[2] = cmd.req.dep_id_2;
      dep_in[3] = cmd.req.dep_id_3;
   end

   // lowest free slot, id match and list predecessor
   always_comb begin
      free_slot  = '0;
      match_slot = '0;
      match_hit  = 1'b0;
      pred_slot  = '0;
      pred_hit   = 1'b0;
      for (int s = QUEUE_DEPTH - 1; s >= 0; s--) begin
         if (!valid_ff[s]) begin
            free_slot = IW'(s);
         end
         if (valid_ff[s] && id_ff[s] == dep_cur) begin
            match_slot = IW'(s);
            match_hit  = 1'b1;
         end
         if (valid_ff[s] && link_ff[s] == PW'(cur_ff)) begin
            pred_slot = IW'(s);
            pred_hit  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         head_ff      <= NONE;
         id_ctr_ff    <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid && out_free) begin
                  if (cmd.req.action == ACT_POP) begin
                     if (head_ff == NONE || used_ff == '0) begin
                        rsp_ff       <= status_rsp(ST_EMPTY, used_ff);
                        rsp_valid_ff <= 1'b1;
                     end else begin
                        rsp_valid_ff <= 1'b0;
                        cur_ff       <= head_ff[IW-1:0];
                        n_ff         <= '0;
                        dep_idx_ff   <= '0;
                        state_ff     <= S_POP_SCAN;
                     end
                  end else if (cmd.bad_deps) begin
                     rsp_ff       <= status_rsp(ST_TOO_MANY, used_ff);
                     rsp_valid_ff <= 1'b1;
                  end else if (used_ff >= DEPTH) begin
                     rsp_ff       <= status_rsp(ST_POOL_FULL, used_ff);
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     rsp_valid_ff        <= 1'b0;
                     valid_ff[free_slot] <= 1'b1;
                     prio_ff[free_slot]  <= cmd.req.priority_req;
                     id_ff[free_slot]    <= id_next;
                     hnd_ff[free_slot]   <= cmd.req.handler;
                     ctx_ff[free_slot]   <= cmd.req.user_context;
                     for (int i = 0; i < MAX_DEPENDS; i++) begin
                        deps_ff[free_slot][i] <= (3'(i) < cmd.req.dep_count) ? dep_in[i] : '0;
                     end
                     id_ctr_ff   <= (id_next == ID_MAX) ? '0 : id_next;
                     new_slot_ff <= free_slot;
                     add_prio_ff <= cmd.req.priority_req;
                     walk_ff     <= head_ff;
                     prev_ff     <= NONE;
                     state_ff    <= S_ADD_WALK;
                  end
               end else if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            S_ADD_WALK: begin
               // one list entry per cycle until a lower priority or the tail
               if (walk_ff != NONE && prio_ff[walk_idx] >= add_prio_ff) begin
                  prev_ff <= walk_ff;
                  walk_ff <= link_ff[walk_idx];
               end else begin
                  link_ff[new_slot_ff] <= walk_ff;
                  if (prev_ff == NONE) begin
                     head_ff <= PW'(new_slot_ff);
                  end else begin
                     link_ff[prev_ff[IW-1:0]] <= PW'(new_slot_ff);
                  end
                  used_ff      <= used_ff + PW'(1);
                  rsp_ff       <= {ST_ADDED, id_ff[new_slot_ff], 8'd0, 32'd0, 32'd0,
                                   5'(used_ff + PW'(1))};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_POP_SCAN: begin
               // one dependency id per cycle
               if (dep_cur != '0 && match_hit) begin
                  last_slot_ff <= cur_ff;
                  last_via_ff  <= dep_idx_ff;
                  n_ff         <= n_ff + PW'(1);
                  cur_ff       <= match_slot;
                  dep_idx_ff   <= '0;
                  if (32'(n_ff) + 2 >= QUEUE_DEPTH) begin
                     state_ff <= S_POP_FIN;
                  end
               end else begin
                  if (dep_cur != '0) begin
                     deps_ff[cur_ff][dep_idx_ff] <= '0;
                  end
                  if (32'(dep_idx_ff) == MAX_DEPENDS - 1) begin
                     state_ff <= S_POP_FIN;
                  end else begin
                     dep_idx_ff <= dep_idx_ff + DW'(1);
                  end
               end
            end
            S_POP_FIN: begin
               if (n_ff != '0) begin
                  deps_ff[last_slot_ff][last_via_ff] <= '0;
               end
               if (head_ff == PW'(cur_ff)) begin
                  head_ff <= link_ff[cur_ff];
               end else if (pred_hit) begin
                  link_ff[pred_slot] <= link_ff[cur_ff];
               end
               valid_ff[cur_ff] <= 1'b0;
               used_ff          <= used_ff - PW'(1);
               rsp_ff           <= {ST_POPPED, id_ff[cur_ff], prio_ff[cur_ff], hnd_ff[cur_ff],
                                    ctx_ff[cur_ff], 5'(used_ff - PW'(1))};
               rsp_valid_ff     <= 1'b1;
               state_ff         <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `PEQD_ASSERT_ALWAYS(a_used_bound, clock, reset, used_ff <= DEPTH, "used count above depth")
   `PEQD_ASSERT_IMPLY(a_walk_bound, clock, reset, state_ff == S_POP_SCAN,
      32'(n_ff) + 1 < QUEUE_DEPTH, "dependency walk too long")
   `PEQD_ASSERT_IMPLY(a_empty_head, clock, reset, head_ff == NONE, used_ff == '0,
      "empty list with events counted")
   `PEQD_ASSERT_IMPLY(a_no_overwrite, clock, reset, state_ff != S_IDLE && rsp_valid_ff,
      rsp_stall || (state_ff == S_POP_SCAN) || (state_ff == S_ADD_WALK) || !rsp_valid_ff,
      "response pending while finishing")

endmodule

// ===== hw/rtl/priority_event_queue_with_dependencies.sv =====
// ----------------------------------------------------------------------------
// priority_event_queue_with_dependencies
// Bounded priority event queue whose pop follows dependency chains.
// ----------------------------------------------------------------------------
//  channel | ports                        | payload
//  --------+------------------------------+---------------
//  request | req_valid, req_stall         | peqd_req_type
//  result  | rsp_valid, rsp_stall         | peqd_rsp_type
//
//  Add: the list walk passes each queued event of equal or higher priority.
//  Pop: the walk looks at dependency ids along the chain, at most about
//  QUEUE_DEPTH * MAX_DEPENDS of them; rejects and empty pops need no walk.
//  The engine's single sequencer sets the rate; the front queues two requests.
//  Reset is synchronous; slot contents need no clearing, only valid bits.
//  A stalled result holds the engine in idle; the front accepts until its two entries are full.
module priority_event_queue_with_dependencies import peqd_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int MAX_DEPENDS = MAX_DEPENDS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  peqd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output peqd_rsp_type rsp_data
);

   logic         cmd_valid;
   logic         cmd_take;
   peqd_cmd_type cmd;

   // front: request intake and classification
   peqd_front #(
      .MAX_DEPENDS (MAX_DEPENDS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   // back: slot store, list walk, dependency walk
   peqd_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .MAX_DEPENDS (MAX_DEPENDS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
